FILE: design/plfa_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// plfa_pkg
// Shared widths, constants and sequencer states of the price level fill
// allocator.
// ============================================================================
package plfa_pkg;

    localparam int ID_W      = 32;
    localparam int QTY_W     = 32;
    localparam int ENTRY_W   = ID_W + QTY_W;
    localparam int DIV_STEPS = 32;
    localparam int STEP_W    = 5;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_F_RD   = 9'b000000010,
        S_F_USE  = 9'b000000100,
        S_P_RD   = 9'b000001000,
        S_P_MUL  = 9'b000010000,
        S_P_DIV  = 9'b000100000,
        S_P_WR   = 9'b001000000,
        S_E_RD   = 9'b010000000,
        S_E_EMIT = 9'b100000000
    } state_t;

endpackage

FILE: design/plfa_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// plfa_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module plfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/price_level_fill_allocator_core.sv
`timescale 1ns / 1ps
// ============================================================================
// price_level_fill_allocator_core
// Resting order book for one price level with FIFO and pro-rata matching.
// ============================================================================
// A load transaction leaves busy low, so loads can follow one another every
// cycle. A match transaction raises busy until its fills are out: FIFO steps
// through a book RAM read, then compare and subtract, for each fill; pro-rata
// runs a share pass per resting order (read, 32x32 multiply, 32-step shared
// restoring divider, write back) and then a fill pass (read, emit). A match on
// an empty book, or a FIFO match of zero quantity, finishes at once with no
// fill. Each fill is shown for a single cycle on fill_strobe and cannot be held
// off, so the receiver must take it.
module price_level_fill_allocator_core #(
    parameter int MAX_ORDERS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_wdata,
    input  logic                     start,
    output logic                     busy,
    input  logic                     action,
    input  logic [plfa_pkg::ID_W-1:0]  rest_id,
    input  logic [plfa_pkg::QTY_W-1:0] quantity,
    output logic                     fill_strobe,
    output logic [plfa_pkg::ID_W-1:0]  fill_order_id,
    output logic [plfa_pkg::QTY_W-1:0] fill_qty,
    output logic                     last_fill
);

    import plfa_pkg::*;

    localparam int CNT_W = $clog2(MAX_ORDERS + 1);
    localparam int IDX_W = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int TOT_W = QTY_W + CNT_W;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 match_mode_reg;
    logic                 fill_strobe_reg, fill_strobe_next;

    logic [QTY_W-1:0]     remaining_reg, remaining_next;
    logic [QTY_W-1:0]     alloc_reg, alloc_next;
    logic [QTY_W-1:0]     given_reg, given_next;
    logic [TOT_W-1:0]     rem_reg, rem_next;
    logic [QTY_W-1:0]     quo_reg, quo_next;
    logic [ID_W-1:0]      hold_id_reg, hold_id_next;
    logic [ID_W-1:0]      fill_id_reg, fill_id_next;
    logic [QTY_W-1:0]     fill_qty_reg, fill_qty_next;
    logic                 last_fill_reg, last_fill_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [ID_W-1:0]      rd_id;
    logic [QTY_W-1:0]     rd_qty;

    logic                 accept;
    logic                 last_idx;
    logic [QTY_W-1:0]     fifo_fill;
    logic [TOT_W:0]       trial;
    logic                 trial_ge;
    logic [2*QTY_W-1:0]   product;
    logic [QTY_W-1:0]     share;

    plfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ORDERS)
    ) u_book (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_id    = ram_rdata[ENTRY_W-1:QTY_W];
    assign rd_qty   = ram_rdata[QTY_W-1:0];
    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign last_idx = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign fifo_fill = (rd_qty < remaining_reg) ? rd_qty : remaining_reg;
    assign trial     = {rem_reg, quo_reg[QTY_W-1]};
    assign trial_ge  = (trial >= {1'b0, total_reg});
    assign product   = alloc_reg * rd_qty;
    assign share     = (total_reg == '0) ? '0 : quo_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        idx_next         = idx_reg;
        step_next        = step_reg;
        fill_strobe_next = 1'b0;
        remaining_next   = remaining_reg;
        alloc_next       = alloc_reg;
        given_next       = given_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        hold_id_next     = hold_id_reg;
        fill_id_next     = fill_id_reg;
        fill_qty_next    = fill_qty_reg;
        last_fill_next   = last_fill_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        ram_wdata        = {hold_id_reg, share};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    if (!action)
                    begin
                        if (count_reg < CNT_W'(MAX_ORDERS))
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[IDX_W-1:0];
                            ram_wdata  = {rest_id, quantity};
                            count_next = count_reg + CNT_W'(1);
                            total_next = total_reg + TOT_W'(quantity);
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        if (!match_mode_reg)
                        begin
                            if (quantity == '0)
                            begin
                                count_next = '0;
                                total_next = '0;
                            end
                            else
                            begin
                                remaining_next = quantity;
                                state_next     = S_F_RD;
                            end
                        end
                        else
                        begin
                            alloc_next = (TOT_W'(quantity) < total_reg) ? quantity
                                                                       : total_reg[QTY_W-1:0];
                            given_next = '0;
                            state_next = S_P_RD;
                        end
                    end
                end
            end

            S_F_RD:
            begin
                state_next = S_F_USE;
            end

            S_F_USE:
            begin
                fill_strobe_next = 1'b1;
                fill_id_next     = rd_id;
                fill_qty_next    = fifo_fill;
                last_fill_next   = last_idx || (rd_qty >= remaining_reg);
                if (last_idx || (rd_qty >= remaining_reg))
                begin
                    count_next = '0;
                    total_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    remaining_next = remaining_reg - fifo_fill;
                    idx_next       = idx_reg + IDX_W'(1);
                    state_next     = S_F_RD;
                end
            end

            S_P_RD:
            begin
                state_next = S_P_MUL;
            end

            S_P_MUL:
            begin
                hold_id_next = rd_id;
                rem_next     = TOT_W'(product[2*QTY_W-1:QTY_W]);
                quo_next     = product[QTY_W-1:0];
                step_next    = '0;
                state_next   = S_P_DIV;
            end

            S_P_DIV:
            begin
                rem_next  = trial_ge ? TOT_W'(trial - {1'b0, total_reg}) : TOT_W'(trial);
                quo_next  = {quo_reg[QTY_W-2:0], trial_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_P_WR;
                end
            end

            S_P_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = {hold_id_reg, share};
                given_next = given_reg + share;
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = S_E_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_P_RD;
                end
            end

            S_E_RD:
            begin
                state_next = S_E_EMIT;
            end

            S_E_EMIT:
            begin
                fill_strobe_next = 1'b1;
                fill_id_next     = rd_id;
                fill_qty_next    = (idx_reg == '0) ? (rd_qty + (alloc_reg - given_reg))
                                                   : rd_qty;
                last_fill_next   = last_idx;
                if (last_idx)
                begin
                    count_next = '0;
                    total_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_E_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            total_reg       <= '0;
            idx_reg         <= '0;
            step_reg        <= '0;
            match_mode_reg  <= 1'b0;
            fill_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            total_reg       <= total_next;
            idx_reg         <= idx_next;
            step_reg        <= step_next;
            fill_strobe_reg <= fill_strobe_next;
            if (cfg_we)
            begin
                match_mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        remaining_reg <= remaining_next;
        alloc_reg     <= alloc_next;
        given_reg     <= given_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        hold_id_reg   <= hold_id_next;
        fill_id_reg   <= fill_id_next;
        fill_qty_reg  <= fill_qty_next;
        last_fill_reg <= last_fill_next;
    end

    assign fill_strobe   = fill_strobe_reg;
    assign fill_order_id = fill_id_reg;
    assign fill_qty      = fill_qty_reg;
    assign last_fill     = last_fill_reg;

endmodule

FILE: design/plfa_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// plfa_checker
// Port level checks of the fill allocator sequencing, bound to the top level.
// ============================================================================
module plfa_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic action,
    input logic fill_strobe,
    input logic last_fill
);

    // more fills of this match still to come
    a_mid_fill_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_strobe && !last_fill) |-> busy)
        else $error("non-final fill while not busy");

    // a new transaction never yields a fill in the next cycle
    a_accept_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !fill_strobe)
        else $error("fill straight after accepted transaction");

    // nothing follows the final fill
    a_last_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_strobe && last_fill) |=> !fill_strobe)
        else $error("fill after final fill");

    // only a match transaction makes the block busy
    a_busy_from_match: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && action))
        else $error("busy without accepted match");

endmodule

bind price_level_fill_allocator_core plfa_checker u_plfa_checker (.*);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the price level fill allocator core. A queue of
// load and match transactions, mode writes and drain points is built up
// front and fed to the block by a clocked driver with random gaps. The
// driver predicts the fills of every accepted match from its own copy of the
// book. A clocked monitor checks each fill against the oldest predicted one.
// ============================================================================
module testbench;

    import plfa_pkg::*;

    localparam int BOOK_DEPTH   = 16;
    localparam int SETTLE       = 48;
    localparam int TAIL         = 64;
    localparam int RANDOM_ITEMS = 430;

    localparam logic ACT_LOAD     = 1'b0;
    localparam logic ACT_MATCH    = 1'b1;
    localparam logic MODE_FIFO    = 1'b0;
    localparam logic MODE_PRORATA = 1'b1;

    typedef enum logic [1:0] {
        K_LOAD,
        K_MATCH,
        K_MODE,
        K_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t       kind;
        logic [ID_W-1:0]  id;
        logic [QTY_W-1:0] qty;
        int               gap;
        logic             mode;
    } step_t;

    typedef struct {
        logic [ID_W-1:0]  id;
        logic [QTY_W-1:0] qty;
        logic             last;
    } fill_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_wdata = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             action = ACT_LOAD;
    logic [ID_W-1:0]  rest_id = '0;
    logic [QTY_W-1:0] quantity = '0;
    logic             fill_strobe;
    logic [ID_W-1:0]  fill_order_id;
    logic [QTY_W-1:0] fill_qty;
    logic             last_fill;

    step_t  pending[$];
    fill_t  fills_due[$];
    step_t  in_flight;

    // book copy used for prediction
    logic [ID_W-1:0]  book_id  [BOOK_DEPTH];
    logic [QTY_W-1:0] book_qty [BOOK_DEPTH];
    int               book_count = 0;
    logic             book_mode = MODE_FIFO;

    int  idle_cycles = 0;
    int  n_queued = 0;
    int  n_loads = 0;
    int  n_matches = 0;
    int  n_fills = 0;
    int  n_mode_writes = 0;
    int  errors = 0;
    bit  burst = 1'b0;

    price_level_fill_allocator_core #(
        .MAX_ORDERS (BOOK_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .rest_id       (rest_id),
        .quantity      (quantity),
        .fill_strobe   (fill_strobe),
        .fill_order_id (fill_order_id),
        .fill_qty      (fill_qty),
        .last_fill     (last_fill)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("timeout at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        return burst ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [QTY_W-1:0] pick_qty();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(1, 100);
            3:       return $urandom_range(1, 100000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [QTY_W-1:0] pick_incoming(input logic [63:0] sum);
        logic [QTY_W-1:0] cap;
        cap = (sum > 64'hFFFF_FFFF) ? '1 : sum[QTY_W-1:0];
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return '1;
            2:       return cap;
            3:       return cap >> 1;
            4:       return $urandom_range(1, 100);
            5:       return $urandom_range(0, cap);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_step(input step_kind_t kind, input logic [ID_W-1:0] id,
                            input logic [QTY_W-1:0] qty, input logic mode);
        step_t s;
        s.kind = kind;
        s.id   = id;
        s.qty  = qty;
        s.gap  = pick_gap();
        s.mode = mode;
        pending.insert(pending.size(), s);
        if (kind == K_LOAD || kind == K_MATCH)
            n_queued++;
    endtask

    task automatic add_load(input logic [ID_W-1:0] id, input logic [QTY_W-1:0] qty);
        add_step(K_LOAD, id, qty, MODE_FIFO);
    endtask

    task automatic add_match(input logic [QTY_W-1:0] qty);
        add_step(K_MATCH, $urandom, qty, MODE_FIFO);
    endtask

    task automatic add_mode(input logic mode);
        add_step(K_MODE, '0, '0, mode);
    endtask

    // allocation of one transaction against the book copy
    task automatic predict_fills(input step_t it);
        logic [QTY_W-1:0] remaining;
        logic [63:0]      total;
        logic [63:0]      alloc;
        logic [63:0]      given;
        logic [63:0]      share;
        fill_t            f;
        fill_t            batch[$];
        if (it.kind == K_LOAD)
        begin
            n_loads++;
            if (book_count < BOOK_DEPTH)
            begin
                book_id[book_count]  = it.id;
                book_qty[book_count] = it.qty;
                book_count++;
            end
        end
        else
        begin
            n_matches++;
            if (book_mode == MODE_FIFO)
            begin
                remaining = it.qty;
                for (int i = 0; i < book_count && remaining != 0; i++)
                begin
                    f.id   = book_id[i];
                    f.qty  = (book_qty[i] < remaining) ? book_qty[i] : remaining;
                    f.last = 1'b0;
                    remaining -= f.qty;
                    batch.insert(batch.size(), f);
                end
            end
            else
            begin
                total = '0;
                given = '0;
                for (int i = 0; i < book_count; i++)
                    total += book_qty[i];
                alloc = ({32'd0, it.qty} < total) ? {32'd0, it.qty} : total;
                for (int i = 0; i < book_count; i++)
                begin
                    share  = (total == 0) ? 64'd0 : (alloc * book_qty[i]) / total;
                    given += share;
                    f.id   = book_id[i];
                    f.qty  = share[QTY_W-1:0];
                    f.last = 1'b0;
                    batch.insert(batch.size(), f);
                end
                // rounding leftover goes to the oldest order
                if (batch.size() != 0 && alloc > given)
                    batch[0].qty = batch[0].qty + QTY_W'(alloc - given);
            end
            if (batch.size() != 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                fills_due.insert(fills_due.size(), batch[i]);
            book_count = 0;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic  raise;
        logic  wr_mode;
        step_t head;
        if (!rst_n)
        begin
            start       <= 1'b0;
            cfg_we      <= 1'b0;
            cfg_wdata   <= MODE_FIFO;
            action      <= ACT_LOAD;
            rest_id     <= '0;
            quantity    <= '0;
            idle_cycles = 0;
        end
        else
        begin
            raise   = start;
            wr_mode = 1'b0;
            if (cfg_we)
                book_mode = cfg_wdata;
            if (start && !busy)
            begin
                predict_fills(in_flight);
                raise       = 1'b0;
                idle_cycles = 0;
            end
            if (!raise && pending.size() != 0)
            begin
                head = pending[0];
                case (head.kind)
                    K_LOAD, K_MATCH:
                    begin
                        if (idle_cycles >= head.gap)
                        begin
                            void'(pending.pop_front());
                            in_flight = head;
                            action    <= (head.kind == K_MATCH) ? ACT_MATCH : ACT_LOAD;
                            rest_id   <= head.id;
                            quantity  <= head.qty;
                            raise     = 1'b1;
                        end
                        else
                            idle_cycles++;
                    end
                    K_MODE:
                    begin
                        // mode writes only once the block has gone quiet
                        if (fills_due.size() == 0 && !busy && !cfg_we)
                        begin
                            if (idle_cycles >= SETTLE)
                            begin
                                void'(pending.pop_front());
                                cfg_wdata   <= head.mode;
                                wr_mode     = 1'b1;
                                idle_cycles = 0;
                                n_mode_writes++;
                            end
                            else
                                idle_cycles++;
                        end
                        else
                            idle_cycles = 0;
                    end
                    default:
                    begin
                        if (fills_due.size() == 0 && !busy)
                        begin
                            void'(pending.pop_front());
                            idle_cycles = 0;
                        end
                    end
                endcase
            end
            start  <= raise;
            cfg_we <= wr_mode;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        fill_t exp_fill;
        if (rst_n && fill_strobe)
        begin
            n_fills++;
            if (fills_due.size() == 0)
            begin
                $display("%0t: unexpected fill id %h qty %h last %b", $time,
                         fill_order_id, fill_qty, last_fill);
                errors++;
            end
            else
            begin
                exp_fill = fills_due.pop_front();
                if (fill_order_id !== exp_fill.id)
                begin
                    $display("%0t: fill_order_id expected %h actual %h", $time,
                             exp_fill.id, fill_order_id);
                    errors++;
                end
                if (fill_qty !== exp_fill.qty)
                begin
                    $display("%0t: fill_qty expected %h actual %h", $time,
                             exp_fill.qty, fill_qty);
                    errors++;
                end
                if (last_fill !== exp_fill.last)
                begin
                    $display("%0t: last_fill expected %b actual %b", $time,
                             exp_fill.last, last_fill);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int          phase;
        int          seqs;
        int          n_orders;
        int          target;
        logic [63:0] load_sum;
        logic [QTY_W-1:0] q;

        // directed, fifo
        add_mode(MODE_FIFO);
        add_match(32'd50);
        add_load(32'h0000_0000, 32'hFFFF_FFFF);
        add_load(32'hFFFF_FFFF, 32'd5);
        add_load(32'h1234_5678, 32'd0);
        add_match(32'd0);
        add_load(32'h0000_00A1, 32'd10);
        add_load(32'h0000_00B2, 32'd20);
        add_load(32'h0000_00C3, 32'd30);
        add_match(32'd25);
        add_load(32'h5555_5555, 32'd0);
        add_load(32'hAAAA_AAAA, 32'h8000_0000);
        add_load(32'h0F0F_0F0F, 32'd7);
        add_match(32'hFFFF_FFFF);
        // directed, pro-rata
        add_mode(MODE_PRORATA);
        add_match(32'd100);
        add_load(32'h0000_0011, 32'd0);
        add_load(32'h0000_0022, 32'd0);
        add_match(32'd100);
        add_load(32'h0000_0031, 32'd1);
        add_load(32'h0000_0032, 32'd2);
        add_load(32'h0000_0034, 32'd4);
        add_match(32'd5);
        add_load(32'hDEAD_0001, 32'hFFFF_FFFF);
        add_load(32'hDEAD_0002, 32'hFFFF_FFFF);
        add_match(32'hFFFF_FFFF);
        add_load(32'h0000_0041, 32'd10);
        add_load(32'h0000_0042, 32'd20);
        add_match(32'd1000);

        // random phases, alternating mode
        target = RANDOM_ITEMS;
        phase  = 0;
        while (n_queued < target)
        begin
            burst = ($urandom_range(0, 3) == 0);
            add_mode(phase[0] ? MODE_PRORATA : MODE_FIFO);
            seqs = $urandom_range(3, 8);
            repeat (seqs)
            begin
                case ($urandom_range(0, 9))
                    0:       n_orders = 0;
                    1:       n_orders = $urandom_range(BOOK_DEPTH, BOOK_DEPTH + 4);
                    default: n_orders = $urandom_range(1, 5);
                endcase
                load_sum = '0;
                for (int k = 0; k < n_orders; k++)
                begin
                    q = pick_qty();
                    if (k < BOOK_DEPTH)
                        load_sum += q;
                    add_load($urandom, q);
                end
                add_match(pick_incoming(load_sum));
                if ($urandom_range(0, 11) == 0)
                    add_step(K_DRAIN, '0, '0, MODE_FIFO);
            end
            phase++;
        end
        add_step(K_DRAIN, '0, '0, MODE_FIFO);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending.size() != 0 || start || busy || fills_due.size() != 0);
        repeat (TAIL) @(negedge clk);
        if (fills_due.size() != 0)
        begin
            $display("%0t: %0d fills never arrived", $time, fills_due.size());
            errors++;
        end

        $display("ran %0d loads and %0d matches across %0d mode writes",
                 n_loads, n_matches, n_mode_writes);
        $display("checked %0d fills, %0d mismatches", n_fills, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
